FILE: src/swf_header_parser_defines.svh
// assertion macros for the swf header parser
// expects clk and rst in the scope where a macro is used
`ifndef SWF_HEADER_PARSER_DEFINES_SVH
`define SWF_HEADER_PARSER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SWFHP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swf header parser: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SWFHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swf header parser: next-cycle check failed");

`endif

FILE: src/swfhp_pkg.sv
// types, character codes and the rectangle bit reader for the swf header parser
// no dependencies
package swfhp_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SIG = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_S = 8'h53;

  localparam int COORD_W = 31;
  localparam int NBITS_W = 5;
  localparam logic [2:0] HDR_LAST = 3'd7;
  localparam logic [2:0] NUM_FIELDS_END = 3'd5;

  typedef struct packed {
    logic [NBITS_W-1:0]           coord_width;
    logic [2:0]                   field_index;
    logic [NBITS_W-1:0]           bits_left;
    logic [COORD_W-1:0]           acc;
    logic [3:0][COORD_W-1:0]      vals;
    logic                         done;
  } rect_t;

  // consume one byte MSB first: 5-bit width, then four signed coordinates
  function automatic rect_t rect_byte(rect_t s, logic [7:0] b);
    rect_t r;
    logic bit_v;
    logic [COORD_W-1:0] v;
    logic [COORD_W-1:0] ext;
    r = s;
    r.done = 1'b0;
    v = '0;
    ext = '0;
    for (int i = 7; i >= 0; i--) begin
      bit_v = b[i];
      if (!r.done) begin
        if (r.field_index == 3'd0) begin
          r.coord_width = {r.coord_width[NBITS_W-2:0], bit_v};
          r.bits_left = r.bits_left - 5'd1;
          if (r.bits_left == '0) begin
            r.acc = '0;
            if (r.coord_width == '0) begin
              r.done = 1'b1;
            end else begin
              r.field_index = 3'd1;
              r.bits_left = r.coord_width;
            end
          end
        end else begin
          r.acc = {r.acc[COORD_W-2:0], bit_v};
          r.bits_left = r.bits_left - 5'd1;
          if (r.bits_left == '0) begin
            v = r.acc;
            ext = {COORD_W{1'b1}} << r.coord_width;
            if (v[r.coord_width - 5'd1]) begin
              v = v | ext;
            end
            r.vals[r.field_index[1:0] - 2'd1] = v;
            r.field_index = r.field_index + 3'd1;
            r.acc = '0;
            if (r.field_index >= NUM_FIELDS_END) begin
              r.done = 1'b1;
            end else begin
              r.bits_left = r.coord_width;
            end
          end
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: src/swf_header_parser.sv
// swf header parser: takes one file byte per transaction and gives one header result.
// A new byte is taken every cycle; the result is registered and appears the cycle after
// the byte that completes, fails or truncates the header. The input stalls only while a
// finished result waits to be taken. Throughput is one byte per cycle while not stalled;
// the rectangle reader walks all eight bits of a byte in one pass of logic.
// depends on swfhp_pkg and swf_header_parser_defines.svh
`include "swf_header_parser_defines.svh"

module swf_header_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  logic [7:0]                data_byte,
  input  logic                      first,
  input  logic                      last,
  output logic                      result_valid,
  input  logic                      result_stall,
  output swfhp_pkg::status_t        status,
  output logic [7:0]                version,
  output logic                      compressed,
  output logic [31:0]               file_size,
  output logic signed [30:0]        x_min,
  output logic signed [30:0]        x_max,
  output logic signed [30:0]        y_min,
  output logic signed [30:0]        y_max,
  output logic [15:0]               frame_rate,
  output logic [15:0]               frame_count
);
  import swfhp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_RECT,
    PH_TAIL
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  byte_count, byte_count_next;
  logic        finished, finished_next;
  logic        sig_ok, sig_ok_next;
  logic        compressed_reg, compressed_next;
  logic [7:0]  version_reg, version_next;
  logic [31:0] size_reg, size_next;
  logic [15:0] rate_reg, rate_next;
  logic [15:0] count_reg, count_next;
  rect_t       rect, rect_next;

  logic        accept;
  logic        emit;
  status_t     emit_status;

  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    finished_next   = finished;
    sig_ok_next     = sig_ok;
    compressed_next = compressed_reg;
    version_next    = version_reg;
    size_next       = size_reg;
    rate_next       = rate_reg;
    count_next      = count_reg;
    rect_next       = rect;
    emit            = 1'b0;
    emit_status     = ST_OK;

    if (accept) begin
      if (first) begin
        phase_next      = PH_HEAD;
        byte_count_next = '0;
        finished_next   = 1'b0;
        sig_ok_next     = 1'b0;
        compressed_next = 1'b0;
        version_next    = '0;
        size_next       = '0;
        rate_next       = '0;
        count_next      = '0;
        rect_next       = '0;
      end
      if (!finished_next) begin
        case (phase_next)
          PH_HEAD: begin
            case (byte_count_next)
              3'd0: begin
                sig_ok_next     = (data_byte == CH_F) || (data_byte == CH_C);
                compressed_next = (data_byte == CH_C);
              end
              3'd1: begin
                if (data_byte != CH_W) sig_ok_next = 1'b0;
              end
              3'd2: begin
                if (data_byte != CH_S) sig_ok_next = 1'b0;
              end
              3'd3: version_next = data_byte;
              default: begin
                // size bytes 4..7, little-endian
                case (byte_count_next[1:0])
                  2'd0:    size_next[7:0]   = data_byte;
                  2'd1:    size_next[15:8]  = data_byte;
                  2'd2:    size_next[23:16] = data_byte;
                  default: size_next[31:24] = data_byte;
                endcase
              end
            endcase
            if (byte_count_next == HDR_LAST) begin
              if (!sig_ok_next) begin
                emit        = 1'b1;
                emit_status = ST_BAD_SIG;
              end else begin
                phase_next          = PH_RECT;
                rect_next           = '0;
                rect_next.bits_left = NBITS_W'(NBITS_W);
              end
            end else begin
              byte_count_next = byte_count_next + 3'd1;
            end
            if (!emit && last) begin
              emit        = 1'b1;
              emit_status = ST_SHORT;
            end
          end
          PH_RECT: begin
            rect_next = rect_byte(rect_next, data_byte);
            if (rect_next.done) begin
              phase_next      = PH_TAIL;
              byte_count_next = '0;
            end
            if (last) begin
              emit        = 1'b1;
              emit_status = ST_SHORT;
            end
          end
          PH_TAIL: begin
            case (byte_count_next[1:0])
              2'd0:    rate_next[7:0]   = data_byte;
              2'd1:    rate_next[15:8]  = data_byte;
              2'd2:    count_next[7:0]  = data_byte;
              default: count_next[15:8] = data_byte;
            endcase
            if (byte_count_next[1:0] == 2'd3) begin
              emit        = 1'b1;
              emit_status = ST_OK;
            end else begin
              byte_count_next = byte_count_next + 3'd1;
              if (last) begin
                emit        = 1'b1;
                emit_status = ST_SHORT;
              end
            end
          end
          default: ;
        endcase
      end
      if (emit) finished_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD;
      byte_count   <= '0;
      finished     <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      finished   <= finished_next;
      if (!result_valid || !result_stall) begin
        result_valid <= emit;
      end
    end
    sig_ok         <= sig_ok_next;
    compressed_reg <= compressed_next;
    version_reg    <= version_next;
    size_reg       <= size_next;
    rate_reg       <= rate_next;
    count_reg      <= count_next;
    rect           <= rect_next;
    // result payload; error results carry zeros
    if (emit && (!result_valid || !result_stall)) begin
      status <= emit_status;
      if (emit_status == ST_OK) begin
        version     <= version_next;
        compressed  <= compressed_next;
        file_size   <= size_next;
        x_min       <= rect_next.vals[0];
        x_max       <= rect_next.vals[1];
        y_min       <= rect_next.vals[2];
        y_max       <= rect_next.vals[3];
        frame_rate  <= rate_next;
        frame_count <= count_next;
      end else begin
        version     <= '0;
        compressed  <= 1'b0;
        file_size   <= '0;
        x_min       <= '0;
        x_max       <= '0;
        y_min       <= '0;
        y_max       <= '0;
        frame_rate  <= '0;
        frame_count <= '0;
      end
    end
  end

  `SWFHP_ASSERT_SAME(a_err_zero, result_valid && (status != ST_OK), (file_size == '0) && (version == '0) && !compressed)
  `SWFHP_ASSERT_NEXT(a_idle_silent, accept && finished && !first, !result_valid)
  `SWFHP_ASSERT_SAME(a_rect_width, (phase == PH_RECT) && (rect.field_index != 3'd0), rect.coord_width != '0)
  `SWFHP_ASSERT_NEXT(a_one_byte_short, accept && first && last, result_valid && (status == ST_SHORT))

endmodule
